### hdl/rcse_pkg.sv
// Shared types and constants of the Rice-coded set encoder.
`default_nettype none

package rcse_pkg;

   // Fixed field widths of the streams.
   localparam int SET_VALUE_BITS = 32;
   localparam int CODE_BYTE_BITS = 8;
   localparam int RICE_K_BITS    = 6;
   localparam int RSP_USER_BITS  = 3;

   // Defaults of the top-level parameters.
   localparam int VALUE_BITS_DEF   = 32;
   localparam int MAX_QUOTIENT_DEF = 255;
   localparam int MAX_RICE_K_DEF   = 32;
   localparam int QUEUE_DEPTH_DEF  = 2;

   // Rice parameter after reset.
   localparam logic [RICE_K_BITS-1:0] RICE_K_RESET = 6'd8;

   // Per-item flags that travel with a coding command.
   typedef struct packed {
      logic final_item;
      logic overflow;
   } rcse_flags_type;

endpackage

`default_nettype wire

### hdl/rice_coded_set_encoder.sv
// Top level of the Rice-coded set encoder.
//
//   Channel | Direction | Handshake            | Contents
//   req     | in        | req_tvalid/tready    | tdata set_value, tlast final_value
//   rsp     | out       | rsp_tvalid/tready    | tdata code_byte, tlast run_last,
//           |           |                      | tuser byte_valid/stream_end/overflow
//   csr     | in        | csr_valid/csr_ready  | csr_data rice_k
//
// The front end takes one set value per cycle, while the queue has room, into a
// two-entry command queue. The packer loads a command, then packs each byte
// window that the unary run touches and each window that the one bit and
// remainder touch, and ends with a marker or a flush where the item needs one.
// Long unary runs give one byte per cycle while the output is not held. Reset
// is synchronous, with no clearing pass. A low rsp_tready holds the packer, and
// the queue keeps accepting until it is full.
`default_nettype none

module rice_coded_set_encoder
   import rcse_pkg::*;
#(
   parameter int VALUE_BITS   = VALUE_BITS_DEF,
   parameter int MAX_QUOTIENT = MAX_QUOTIENT_DEF,
   parameter int MAX_RICE_K   = MAX_RICE_K_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Input stream.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [SET_VALUE_BITS-1:0] req_tdata,   // [31:0] set_value
   input  wire logic                      req_tlast,   // final_value
   // Result stream.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [CODE_BYTE_BITS-1:0]      rsp_tdata,   // [7:0] code_byte
   output logic                           rsp_tlast,   // run_last
   output logic [RSP_USER_BITS-1:0]       rsp_tuser,   // [0] byte_valid, [1] stream_end,
                                                       // [2] quotient_overflow
   // Rice parameter register.
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [RICE_K_BITS-1:0]    csr_data     // [5:0] rice_k
);

   localparam int QW = $clog2(MAX_QUOTIENT + 1);
   localparam int LW = $clog2(MAX_RICE_K + 2);
   localparam int CMD_BITS = QW + VALUE_BITS + 1 + LW + $bits(rcse_flags_type);

   logic [RICE_K_BITS-1:0] rice_k_ff;

   logic                   f_valid, f_ready;
   logic [QW-1:0]          f_zeros;
   logic [VALUE_BITS:0]    f_tail;
   logic [LW-1:0]          f_tail_len;
   rcse_flags_type         f_flags;

   logic                   b_valid, b_ready;
   logic [CMD_BITS-1:0]    b_data;
   logic [QW-1:0]          b_zeros;
   logic [VALUE_BITS:0]    b_tail;
   logic [LW-1:0]          b_tail_len;
   rcse_flags_type         b_flags;

   logic                   byte_valid, stream_end, overflow;

   // Rice parameter register; every transfer is taken at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rice_k_ff <= RICE_K_RESET;
      end else if (csr_valid) begin
         rice_k_ff <= csr_data;
      end
   end

   rcse_front #(
      .VALUE_BITS   (VALUE_BITS),
      .MAX_QUOTIENT (MAX_QUOTIENT),
      .MAX_RICE_K   (MAX_RICE_K)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .rice_k       (rice_k_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .set_value    (req_tdata),
      .final_value  (req_tlast),
      .cmd_valid    (f_valid),
      .cmd_ready    (f_ready),
      .cmd_zeros    (f_zeros),
      .cmd_tail     (f_tail),
      .cmd_tail_len (f_tail_len),
      .cmd_flags    (f_flags)
   );

   rcse_queue #(
      .DATA_BITS (CMD_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  ({f_zeros, f_tail, f_tail_len, f_flags}),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_data  (b_data)
   );

   assign {b_zeros, b_tail, b_tail_len, b_flags} = b_data;

   rcse_back #(
      .VALUE_BITS   (VALUE_BITS),
      .MAX_QUOTIENT (MAX_QUOTIENT),
      .MAX_RICE_K   (MAX_RICE_K)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (b_valid),
      .cmd_ready      (b_ready),
      .cmd_zeros      (b_zeros),
      .cmd_tail       (b_tail),
      .cmd_tail_len   (b_tail_len),
      .cmd_flags      (b_flags),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_code_byte  (rsp_tdata),
      .rsp_byte_valid (byte_valid),
      .rsp_run_last   (rsp_tlast),
      .rsp_stream_end (stream_end),
      .rsp_overflow   (overflow)
   );

   assign rsp_tuser = {overflow, stream_end, byte_valid};

endmodule

`default_nettype wire

### hdl/rcse_front.sv
// Front end: accepts set values, forms deltas and builds coding commands.
`default_nettype none

module rcse_front
   import rcse_pkg::*;
#(
   parameter int VALUE_BITS   = VALUE_BITS_DEF,
   parameter int MAX_QUOTIENT = MAX_QUOTIENT_DEF,
   parameter int MAX_RICE_K   = MAX_RICE_K_DEF,
   localparam int QW = $clog2(MAX_QUOTIENT + 1),
   localparam int LW = $clog2(MAX_RICE_K + 2)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [RICE_K_BITS-1:0]    rice_k,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [SET_VALUE_BITS-1:0] set_value,
   input  wire logic                      final_value,
   output logic                           cmd_valid,
   input  wire logic                      cmd_ready,
   output logic [QW-1:0]                  cmd_zeros,
   output logic [VALUE_BITS:0]            cmd_tail,
   output logic [LW-1:0]                  cmd_tail_len,
   output rcse_flags_type                 cmd_flags
);

   localparam int CW = (VALUE_BITS > QW) ? VALUE_BITS : QW;
   localparam logic [RICE_K_BITS-1:0] K_LIMIT = RICE_K_BITS'(MAX_RICE_K);

   logic [VALUE_BITS-1:0]  prev_ff, prev_in;
   logic                   first_ff, first_in;

   logic [63:0]            wide_value;
   logic [VALUE_BITS-1:0]  value;
   logic [VALUE_BITS-1:0]  delta;
   logic [VALUE_BITS-1:0]  quot;
   logic [CW-1:0]          quot_wide;
   logic [VALUE_BITS-1:0]  remainder;
   logic [RICE_K_BITS-1:0] k_eff;
   logic                   code_it;
   logic                   too_long;
   logic                   write_bits;
   logic                   accept;

   // Delta, quotient and remainder of the incoming value.
   assign wide_value = 64'(set_value);
   assign value      = wide_value[VALUE_BITS-1:0];
   assign k_eff      = (rice_k > K_LIMIT) ? K_LIMIT : rice_k;
   assign delta      = value - prev_ff;
   assign code_it    = first_ff || (value > prev_ff);
   assign quot       = delta >> k_eff;
   assign quot_wide  = CW'(quot);
   assign too_long   = quot_wide > CW'(MAX_QUOTIENT);
   assign remainder  = delta & ~({VALUE_BITS{1'b1}} << k_eff);
   assign write_bits = code_it && !too_long;

   // Command toward the back end: unary length, then one bit and the remainder.
   assign cmd_valid            = in_valid;
   assign in_ready             = cmd_ready;
   assign accept               = in_valid && cmd_ready;
   assign cmd_zeros            = write_bits ? quot_wide[QW-1:0] : '0;
   assign cmd_tail             = {remainder, 1'b1};
   assign cmd_tail_len         = write_bits ? (LW'(k_eff) + LW'(1)) : '0;
   assign cmd_flags.final_item = final_value;
   assign cmd_flags.overflow   = code_it && too_long;

   // Previous-value tracking; a final item starts a new stream.
   always_comb begin
      prev_in  = prev_ff;
      first_in = first_ff;
      if (accept) begin
         if (final_value) begin
            prev_in  = '0;
            first_in = 1'b1;
         end else if (write_bits) begin
            prev_in  = value;
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         prev_ff  <= prev_in;
         first_ff <= first_in;
      end
   end

   // A transfer marked final leaves the tracking state at its reset value.
   assert property (@(posedge clock) disable iff (reset)
      accept && final_value |=> first_ff && (prev_ff == '0))
      else $error("front state not cleared after final item");

endmodule

`default_nettype wire

### hdl/rcse_queue.sv
// Short command queue between the front end and the bit packer.
`default_nettype none

module rcse_queue
   import rcse_pkg::*;
#(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = QUEUE_DEPTH_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int NW = $clog2(DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_valid,
   output logic                      wr_ready,
   input  wire logic [DATA_BITS-1:0] wr_data,
   output logic                      rd_valid,
   input  wire logic                 rd_ready,
   output logic [DATA_BITS-1:0]      rd_data
);

   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [NW-1:0] FULL_FILL = NW'(DEPTH);

   logic [DATA_BITS-1:0] slots [DEPTH];
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]        fill_ff, fill_in;
   logic                 push, pop;

   assign wr_ready = fill_ff != FULL_FILL;
   assign rd_valid = fill_ff != '0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = slots[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage is written on each push transfer.
   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= wr_data;
      end
   end

   // The fill level never passes the depth.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= FULL_FILL)
      else $error("queue fill level above depth");

   // An empty queue has its pointers equal.
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with empty fill level");

endmodule

`default_nettype wire

### hdl/rcse_back.sv
// Back end: packs unary and remainder bits into bytes and drives the results.
`default_nettype none

module rcse_back
   import rcse_pkg::*;
#(
   parameter int VALUE_BITS   = VALUE_BITS_DEF,
   parameter int MAX_QUOTIENT = MAX_QUOTIENT_DEF,
   parameter int MAX_RICE_K   = MAX_RICE_K_DEF,
   localparam int QW = $clog2(MAX_QUOTIENT + 1),
   localparam int LW = $clog2(MAX_RICE_K + 2)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      cmd_valid,
   output logic                           cmd_ready,
   input  wire logic [QW-1:0]             cmd_zeros,
   input  wire logic [VALUE_BITS:0]       cmd_tail,
   input  wire logic [LW-1:0]             cmd_tail_len,
   input  wire rcse_flags_type            cmd_flags,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [CODE_BYTE_BITS-1:0]      rsp_code_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_run_last,
   output logic                           rsp_stream_end,
   output logic                           rsp_overflow
);

   localparam int ZW  = (QW > 4) ? QW : 4;
   localparam int TLW = (LW > 4) ? LW : 4;
   localparam int RB  = (QW > LW) ? QW : LW;
   localparam int RW  = ((RB > 3) ? RB : 3) + 1;

   // Item being packed.
   logic                busy_ff, busy_in;
   logic [QW-1:0]       zeros_ff, zeros_in;
   logic [VALUE_BITS:0] tail_ff, tail_in;
   logic [LW-1:0]       tail_len_ff, tail_len_in;
   rcse_flags_type      flags_ff, flags_in;
   logic                emitted_ff, emitted_in;

   // Unfinished byte.
   logic [7:0]          partial_ff, partial_in;
   logic [2:0]          cnt_ff, cnt_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_bvalid_ff, rsp_bvalid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_end_ff, rsp_end_in;
   logic                rsp_over_ff, rsp_over_in;

   // One packing step.
   logic                out_ok;
   logic                use_zeros;
   logic                work_left;
   logic [3:0]          free;
   logic [ZW-1:0]       zeros_ext;
   logic [TLW-1:0]      tail_len_ext;
   logic [3:0]          n_zeros, n_tail, n;
   logic [3:0]          cnt_sum;
   logic [8:0]          take_mask;
   logic [15:0]         chunk;
   logic [7:0]          bits_new;
   logic [QW-1:0]       zeros_step;
   logic [VALUE_BITS:0] tail_step;
   logic [LW-1:0]       tail_len_step;
   logic [RW-1:0]       bits_left;
   logic                look_last;
   logic [2:0]          cnt_after;

   assign cmd_ready = !busy_ff;
   assign out_ok    = !rsp_valid_ff || rsp_ready;

   // Fill the free part of the byte from the unary run, else from the tail.
   always_comb begin
      work_left     = (zeros_ff != '0) || (tail_len_ff != '0);
      use_zeros     = zeros_ff != '0;
      free          = 4'd8 - {1'b0, cnt_ff};
      zeros_ext     = ZW'(zeros_ff);
      tail_len_ext  = TLW'(tail_len_ff);
      n_zeros       = (zeros_ext < ZW'(free)) ? zeros_ext[3:0] : free;
      n_tail        = (tail_len_ext < TLW'(free)) ? tail_len_ext[3:0] : free;
      n             = use_zeros ? n_zeros : n_tail;
      cnt_sum       = {1'b0, cnt_ff} + n;
      take_mask     = (9'd1 << n) - 9'd1;
      chunk         = 16'({8'b0, tail_ff[7:0] & take_mask[7:0]} << cnt_ff);
      bits_new      = use_zeros ? partial_ff : (partial_ff | chunk[7:0]);
      zeros_step    = use_zeros ? (zeros_ff - QW'(n)) : zeros_ff;
      tail_step     = use_zeros ? tail_ff : (tail_ff >> n);
      tail_len_step = use_zeros ? tail_len_ff : (tail_len_ff - LW'(n));
      cnt_after     = cnt_sum[3] ? 3'd0 : cnt_sum[2:0];
      bits_left     = RW'(zeros_step) + RW'(tail_len_step);
      // A full byte is the item's last result when what remains cannot
      // fill another byte and needs no flush.
      look_last     = flags_ff.final_item ? (bits_left == '0) : (bits_left < RW'(8));
   end

   // Item sequencing and result selection.
   always_comb begin
      busy_in       = busy_ff;
      zeros_in      = zeros_ff;
      tail_in       = tail_ff;
      tail_len_in   = tail_len_ff;
      flags_in      = flags_ff;
      emitted_in    = emitted_ff;
      partial_in    = partial_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_over_in   = rsp_over_ff;

      if (out_ok) begin
         rsp_valid_in = 1'b0;
      end

      if (!busy_ff) begin
         if (cmd_valid) begin
            busy_in     = 1'b1;
            zeros_in    = cmd_zeros;
            tail_in     = cmd_tail;
            tail_len_in = cmd_tail_len;
            flags_in    = cmd_flags;
            emitted_in  = 1'b0;
         end
      end else if (out_ok) begin
         rsp_over_in = flags_ff.overflow;
         if (work_left) begin
            zeros_in    = zeros_step;
            tail_in     = tail_step;
            tail_len_in = tail_len_step;
            partial_in  = cnt_sum[3] ? 8'd0 : bits_new;
            cnt_in      = cnt_after;
            if (cnt_sum[3]) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = bits_new;
               rsp_bvalid_in = 1'b1;
               rsp_last_in   = look_last;
               rsp_end_in    = look_last && flags_ff.final_item;
               emitted_in    = 1'b1;
            end
            if ((zeros_step == '0) && (tail_len_step == '0) &&
                (!flags_ff.final_item || (cnt_after == 3'd0)) &&
                (emitted_ff || cnt_sum[3])) begin
               busy_in = 1'b0;
            end
         end else begin
            busy_in = 1'b0;
            if (flags_ff.final_item && (cnt_ff != 3'd0)) begin
               // Flush of the zero-padded partial byte.
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = partial_ff;
               rsp_bvalid_in = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_end_in    = 1'b1;
               partial_in    = 8'd0;
               cnt_in        = 3'd0;
            end else if (!emitted_ff) begin
               // Marker result for an item that completed no byte.
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = 8'd0;
               rsp_bvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_end_in    = flags_ff.final_item;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         zeros_ff     <= '0;
         tail_len_ff  <= '0;
         emitted_ff   <= 1'b0;
         partial_ff   <= 8'd0;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         zeros_ff     <= zeros_in;
         tail_len_ff  <= tail_len_in;
         emitted_ff   <= emitted_in;
         partial_ff   <= partial_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      tail_ff       <= tail_in;
      flags_ff      <= flags_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_over_ff   <= rsp_over_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_byte  = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_stream_end = rsp_end_ff;
   assign rsp_overflow   = rsp_over_ff;

   // An idle packer holds no leftover bits of an item.
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (zeros_ff == '0) && (tail_len_ff == '0))
      else $error("packer idle with bits left");

   // The end of a stream leaves no partial byte and closes its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> (cnt_ff == 3'd0) && rsp_last_ff)
      else $error("stream ended with partial byte pending");

   // A marker result is empty and is always the last result of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bvalid_ff |-> (rsp_byte_ff == 8'd0) && rsp_last_ff)
      else $error("malformed marker result");

endmodule

`default_nettype wire
